[hdl/tpls_pkg.sv]
// Shared types and constants of the two-peer link supervisor.
`timescale 1ns / 1ps

package tpls_pkg;

   // Result kinds
   localparam logic [1:0] KIND_VERDICT = 2'd0;
   localparam logic [1:0] KIND_TX      = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;

   // Frame verdicts
   localparam logic [2:0] VERDICT_ACCEPTED    = 3'd0;
   localparam logic [2:0] VERDICT_DUPLICATE   = 3'd1;
   localparam logic [2:0] VERDICT_OUT_OF_ORDER = 3'd2;
   localparam logic [2:0] VERDICT_SHADOW      = 3'd3;
   localparam logic [2:0] VERDICT_UNSUPPORTED = 3'd4;

   // Request operations
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [2:0] CSR_OFFLINE_TIMEOUT = 3'd0;
   localparam logic [2:0] CSR_HELLO_INTERVAL  = 3'd1;
   localparam logic [2:0] CSR_HEARTBEAT_INTERVAL = 3'd2;
   localparam logic [2:0] CSR_STATUS_INTERVAL = 3'd3;
   localparam logic [2:0] CSR_MESSAGE_CODES   = 3'd4;
   localparam logic [2:0] CSR_ROLE_CODES      = 3'd5;
   localparam logic [2:0] CSR_STATUS_FLAGS    = 3'd6;

   // Register reset values
   localparam logic [15:0] OFFLINE_TIMEOUT_RESET   = 16'd1000;
   localparam logic [15:0] HELLO_INTERVAL_RESET    = 16'd1000;
   localparam logic [15:0] HEARTBEAT_INTERVAL_RESET = 16'd250;
   localparam logic [15:0] STATUS_INTERVAL_RESET   = 16'd500;

   // Everything one request produces, captured at acceptance.
   typedef struct packed {
      logic        is_tick;
      logic [2:0]  verdict;
      logic        pres_due;
      logic [7:0]  pres_type;
      logic [15:0] pres_seq;
      logic        stat_due;
      logic [7:0]  stat_type;
      logic [15:0] stat_seq;
      logic [31:0] now;
      logic        first_up;
      logic        second_up;
      logic [7:0]  peer_role;
      logic [31:0] rx_count;
      logic [31:0] offline_events;
   } rsp_item_type;

   // One result as it leaves the block.
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  verdict;
      logic [7:0]  tx_type;
      logic [15:0] tx_sequence;
      logic [31:0] tx_time;
      logic        first_online;
      logic        second_online;
      logic        link_online;
      logic [7:0]  peer_role;
      logic [31:0] accepted_frames;
      logic [31:0] offline_events;
      logic        last;
   } rsp_out_type;

endpackage

[hdl/tpls_rsp_buf.sv]
// Result buffer: holds one request's results and hands them out in order.
`timescale 1ns / 1ps

module tpls_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tpls_pkg::rsp_item_type item,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tpls_pkg::rsp_out_type rsp
);

   // Emission slots of one buffered request
   typedef enum logic [1:0] {
      SLOT_HEAD,
      SLOT_PRESENCE,
      SLOT_STATUS
   } slot_type;

   tpls_pkg::rsp_item_type item_ff;
   logic       busy_ff;
   slot_type   step_ff;
   slot_type   step_next;
   logic       has_next;
   logic       take;

   always_comb begin
      step_next = SLOT_HEAD;
      has_next  = 1'b0;
      case (step_ff)
         SLOT_HEAD: begin
            if (item_ff.pres_due) begin
               step_next = SLOT_PRESENCE;
               has_next  = 1'b1;
            end else if (item_ff.stat_due) begin
               step_next = SLOT_STATUS;
               has_next  = 1'b1;
            end
         end
         SLOT_PRESENCE: begin
            if (item_ff.stat_due) begin
               step_next = SLOT_STATUS;
               has_next  = 1'b1;
            end
         end
         default: begin
            has_next = 1'b0;
         end
      endcase
   end

   assign take      = busy_ff && !rsp_stall;
   // A new request may enter as the final result of the current one leaves.
   assign free      = !busy_ff || (take && !has_next);
   assign rsp_valid = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= SLOT_HEAD;
      end else if (load) begin
         busy_ff <= 1'b1;
         step_ff <= SLOT_HEAD;
         item_ff <= item;
      end else if (take) begin
         if (has_next) begin
            step_ff <= step_next;
         end else begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp.result_kind     = tpls_pkg::KIND_TX;
      rsp.verdict         = tpls_pkg::VERDICT_ACCEPTED;
      rsp.tx_type         = 8'd0;
      rsp.tx_sequence     = 16'd0;
      rsp.tx_time         = 32'd0;
      rsp.first_online    = item_ff.first_up;
      rsp.second_online   = item_ff.second_up;
      rsp.link_online     = item_ff.first_up && item_ff.second_up;
      rsp.peer_role       = item_ff.peer_role;
      rsp.accepted_frames = item_ff.rx_count;
      rsp.offline_events  = item_ff.offline_events;
      rsp.last            = !has_next;
      case (step_ff)
         SLOT_HEAD: begin
            if (item_ff.is_tick) begin
               rsp.result_kind = tpls_pkg::KIND_TICK;
            end else begin
               rsp.result_kind = tpls_pkg::KIND_VERDICT;
               rsp.verdict     = item_ff.verdict;
            end
         end
         SLOT_PRESENCE: begin
            rsp.tx_type     = item_ff.pres_type;
            rsp.tx_sequence = item_ff.pres_seq;
            rsp.tx_time     = item_ff.now;
         end
         default: begin
            rsp.tx_type     = item_ff.stat_type;
            rsp.tx_sequence = item_ff.stat_seq;
            rsp.tx_time     = item_ff.now;
         end
      endcase
   end

endmodule

[hdl/two_peer_link_supervisor_top.sv]
// Top level of the two-peer link supervisor: frame judging, tick handling, registers.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Contents
// req_*    in         req_valid / req_stall  frame or tick request
// rsp_*    out        rsp_valid / rsp_stall  verdict, tick status, transmit requests
// csr_*    in         csr_valid / csr_ready  register index and write data
//
// A request is judged in the cycle it is accepted; its results appear on the next cycle.
// A frame yields one result, a tick one to three, one per cycle unless rsp_stall holds them.
// A new request is taken in the same cycle the previous request's last result leaves.
// rsp_stall holds the current result and stalls requests once the buffer is full.
// Synchronous reset clears the link state and empties the result buffer; registers take their defaults.

module two_peer_link_supervisor_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_frame_type,
   input  logic [7:0]  req_frame_length,
   input  logic [7:0]  req_frame_role,
   input  logic [15:0] req_frame_sequence,
   input  logic [31:0] req_now_ms,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_verdict,
   output logic [7:0]  rsp_tx_type,
   output logic [15:0] rsp_tx_sequence,
   output logic [31:0] rsp_tx_time,
   output logic        rsp_first_online,
   output logic        rsp_second_online,
   output logic        rsp_link_online,
   output logic [7:0]  rsp_peer_role,
   output logic [31:0] rsp_accepted_frames,
   output logic [31:0] rsp_offline_events,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tpls_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [39:0] csr_wdata
);

   // Configuration registers
   logic [15:0] offline_timeout_ff, hello_interval_ff, heartbeat_interval_ff;
   logic [15:0] status_interval_ff;
   logic [39:0] message_codes_ff;
   logic [23:0] role_codes_ff;
   logic [7:0]  status_flags_ff;

   // Supervisor state
   logic        first_seen_ff, second_seen_ff, first_up_ff, second_up_ff, started_ff;
   logic [15:0] first_seq_ff, second_seq_ff, own_seq_ff;
   logic [31:0] first_rx_time_ff, second_rx_time_ff;
   logic [31:0] presence_time_ff, status_time_ff;
   logic [7:0]  peer_role_ff;
   logic [31:0] accepted_count_ff, offline_count_ff;

   logic        first_seen_in, second_seen_in, first_up_in, second_up_in, started_in;
   logic [15:0] first_seq_in, second_seq_in, own_seq_in;
   logic [31:0] first_rx_time_in, second_rx_time_in;
   logic [31:0] presence_time_in, status_time_in;
   logic [7:0]  peer_role_in;
   logic [31:0] accepted_count_in, offline_count_in;

   logic        accept;
   logic        buf_free;
   tpls_pkg::rsp_item_type item;
   tpls_pkg::rsp_out_type  rsp;

   // Frame judging
   logic [7:0]  code_shadow, code_estop, code_hello, code_heartbeat, code_status;
   logic [7:0]  role_first, role_second;
   logic        is_shadow, is_supported, is_first, is_second;
   logic        peer_seen;
   logic [15:0] peer_seq, seq_delta;
   logic [2:0]  verdict;
   logic        frame_ok;

   // Tick handling
   logic [31:0] first_age, second_age, presence_age, status_age;
   logic [15:0] presence_period;
   logic        first_up_new, second_up_new, went_offline;
   logic        pres_due, stat_due;

   assign code_shadow    = message_codes_ff[7:0];
   assign code_estop     = message_codes_ff[15:8];
   assign code_hello     = message_codes_ff[23:16];
   assign code_heartbeat = message_codes_ff[31:24];
   assign code_status    = message_codes_ff[39:32];
   assign role_first     = role_codes_ff[7:0];
   assign role_second    = role_codes_ff[15:8];

   assign is_shadow    = (req_frame_type == code_shadow) || (req_frame_type == code_estop);
   assign is_supported = (req_frame_type == code_hello) || (req_frame_type == code_heartbeat)
                         || (req_frame_type == code_status);
   // With equal role codes the first peer takes the frame.
   assign is_first     = (req_frame_role == role_first);
   assign is_second    = !is_first && (req_frame_role == role_second);
   assign peer_seen    = is_first ? first_seen_ff : second_seen_ff;
   assign peer_seq     = is_first ? first_seq_ff : second_seq_ff;
   assign seq_delta    = req_frame_sequence - peer_seq;

   always_comb begin
      if (is_shadow) begin
         verdict = tpls_pkg::VERDICT_SHADOW;
      end else if (!is_supported || (req_frame_length == 8'd0) || !(is_first || is_second)) begin
         verdict = tpls_pkg::VERDICT_UNSUPPORTED;
      end else if ((req_frame_type != code_hello) && peer_seen && (seq_delta == 16'd0)) begin
         verdict = tpls_pkg::VERDICT_DUPLICATE;
      end else if ((req_frame_type != code_hello) && peer_seen && seq_delta[15]) begin
         verdict = tpls_pkg::VERDICT_OUT_OF_ORDER;
      end else begin
         verdict = tpls_pkg::VERDICT_ACCEPTED;
      end
   end
   assign frame_ok = (verdict == tpls_pkg::VERDICT_ACCEPTED);

   // Ages are taken modulo 2^32 so time wrap is harmless.
   assign first_age     = req_now_ms - first_rx_time_ff;
   assign second_age    = req_now_ms - second_rx_time_ff;
   assign presence_age  = req_now_ms - presence_time_ff;
   assign status_age    = req_now_ms - status_time_ff;
   assign first_up_new  = first_seen_ff && (first_age < {16'd0, offline_timeout_ff});
   assign second_up_new = second_seen_ff && (second_age < {16'd0, offline_timeout_ff});
   assign went_offline  = (first_up_ff && !first_up_new) || (second_up_ff && !second_up_new);
   assign presence_period = first_up_new ? heartbeat_interval_ff : hello_interval_ff;
   assign pres_due = !started_ff || (presence_age >= {16'd0, presence_period});
   assign stat_due = !started_ff || (status_age >= {16'd0, status_interval_ff});

   always_comb begin
      first_seen_in     = first_seen_ff;
      second_seen_in    = second_seen_ff;
      first_seq_in      = first_seq_ff;
      second_seq_in     = second_seq_ff;
      first_rx_time_in  = first_rx_time_ff;
      second_rx_time_in = second_rx_time_ff;
      first_up_in       = first_up_ff;
      second_up_in      = second_up_ff;
      peer_role_in      = peer_role_ff;
      accepted_count_in = accepted_count_ff;
      offline_count_in  = offline_count_ff;
      own_seq_in        = own_seq_ff;
      presence_time_in  = presence_time_ff;
      status_time_in    = status_time_ff;
      started_in        = started_ff;
      if (req_operation == tpls_pkg::OP_FRAME) begin
         if (frame_ok) begin
            if (is_first) begin
               first_seen_in    = 1'b1;
               first_seq_in     = req_frame_sequence;
               first_rx_time_in = req_now_ms;
            end else begin
               second_seen_in    = 1'b1;
               second_seq_in     = req_frame_sequence;
               second_rx_time_in = req_now_ms;
            end
            peer_role_in      = req_frame_role;
            accepted_count_in = accepted_count_ff + 32'd1;
         end
      end else begin
         first_up_in  = first_up_new;
         second_up_in = second_up_new;
         if (went_offline) begin
            offline_count_in = offline_count_ff + 32'd1;
         end
         if (pres_due) begin
            presence_time_in = req_now_ms;
         end
         if (stat_due) begin
            status_time_in = req_now_ms;
         end
         own_seq_in = own_seq_ff + {15'd0, pres_due} + {15'd0, stat_due};
         started_in = 1'b1;
      end
   end

   always_comb begin
      item.is_tick        = (req_operation == tpls_pkg::OP_TICK);
      item.verdict        = verdict;
      item.pres_due       = item.is_tick && pres_due;
      item.pres_type      = first_up_new ? code_heartbeat : code_hello;
      item.pres_seq       = own_seq_ff;
      item.stat_due       = item.is_tick && stat_due;
      item.stat_type      = code_status;
      item.stat_seq       = own_seq_ff + {15'd0, pres_due};
      item.now            = req_now_ms;
      item.first_up       = first_up_in;
      item.second_up      = second_up_in;
      item.peer_role      = peer_role_in;
      item.rx_count       = accepted_count_in;
      item.offline_events = offline_count_in;
   end

   assign req_stall = !buf_free;
   assign accept    = req_valid && buf_free;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff     <= 1'b0;
         second_seen_ff    <= 1'b0;
         first_seq_ff      <= 16'd0;
         second_seq_ff     <= 16'd0;
         first_rx_time_ff  <= 32'd0;
         second_rx_time_ff <= 32'd0;
         first_up_ff       <= 1'b0;
         second_up_ff      <= 1'b0;
         peer_role_ff      <= 8'd0;
         accepted_count_ff <= 32'd0;
         offline_count_ff  <= 32'd0;
         own_seq_ff        <= 16'd0;
         presence_time_ff  <= 32'd0;
         status_time_ff    <= 32'd0;
         started_ff        <= 1'b0;
      end else if (accept) begin
         first_seen_ff     <= first_seen_in;
         second_seen_ff    <= second_seen_in;
         first_seq_ff      <= first_seq_in;
         second_seq_ff     <= second_seq_in;
         first_rx_time_ff  <= first_rx_time_in;
         second_rx_time_ff <= second_rx_time_in;
         first_up_ff       <= first_up_in;
         second_up_ff      <= second_up_in;
         peer_role_ff      <= peer_role_in;
         accepted_count_ff <= accepted_count_in;
         offline_count_ff  <= offline_count_in;
         own_seq_ff        <= own_seq_in;
         presence_time_ff  <= presence_time_in;
         status_time_ff    <= status_time_in;
         started_ff        <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offline_timeout_ff    <= tpls_pkg::OFFLINE_TIMEOUT_RESET;
         hello_interval_ff     <= tpls_pkg::HELLO_INTERVAL_RESET;
         heartbeat_interval_ff <= tpls_pkg::HEARTBEAT_INTERVAL_RESET;
         status_interval_ff    <= tpls_pkg::STATUS_INTERVAL_RESET;
         message_codes_ff      <= 40'd0;
         role_codes_ff         <= 24'd0;
         status_flags_ff       <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tpls_pkg::CSR_OFFLINE_TIMEOUT:    offline_timeout_ff    <= csr_wdata[15:0];
            tpls_pkg::CSR_HELLO_INTERVAL:     hello_interval_ff     <= csr_wdata[15:0];
            tpls_pkg::CSR_HEARTBEAT_INTERVAL: heartbeat_interval_ff <= csr_wdata[15:0];
            tpls_pkg::CSR_STATUS_INTERVAL:    status_interval_ff    <= csr_wdata[15:0];
            tpls_pkg::CSR_MESSAGE_CODES:      message_codes_ff      <= csr_wdata;
            tpls_pkg::CSR_ROLE_CODES:         role_codes_ff         <= csr_wdata[23:0];
            tpls_pkg::CSR_STATUS_FLAGS:       status_flags_ff       <= csr_wdata[7:0];
            default: begin
               status_flags_ff <= status_flags_ff;
            end
         endcase
      end
   end

   tpls_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .item      (item),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_result_kind     = rsp.result_kind;
   assign rsp_verdict         = rsp.verdict;
   assign rsp_tx_type         = rsp.tx_type;
   assign rsp_tx_sequence     = rsp.tx_sequence;
   assign rsp_tx_time         = rsp.tx_time;
   assign rsp_first_online    = rsp.first_online;
   assign rsp_second_online   = rsp.second_online;
   assign rsp_link_online     = rsp.link_online;
   assign rsp_peer_role       = rsp.peer_role;
   assign rsp_accepted_frames = rsp.accepted_frames;
   assign rsp_offline_events  = rsp.offline_events;
   assign rsp_last            = rsp.last;

endmodule

[hdl/tpls_checker.sv]
// Port-level checks of the two-peer link supervisor and their binding.
`timescale 1ns / 1ps

module tpls_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [2:0]  rsp_verdict,
   input logic        rsp_first_online,
   input logic        rsp_second_online,
   input logic        rsp_link_online,
   input logic        rsp_last
);

   // A frame verdict is always the only result of its request.
   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == tpls_pkg::KIND_VERDICT) |-> rsp_last)
      else $error("frame verdict not marked last");

   // Results that follow within a request are transmit requests, back to back.
   a_follow_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && (rsp_result_kind == tpls_pkg::KIND_TX))
      else $error("missing transmit request after non-final result");

   // Transmit requests and tick status carry no verdict.
   a_no_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != tpls_pkg::KIND_VERDICT) |->
         (rsp_verdict == tpls_pkg::VERDICT_ACCEPTED))
      else $error("verdict set on non-verdict result");

   // The link is online exactly when both peers are.
   a_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_link_online == (rsp_first_online && rsp_second_online)))
      else $error("link status disagrees with peer status");

   // A request is never taken while a non-final result still waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request accepted while results pending");

endmodule

bind two_peer_link_supervisor_top tpls_checker u_tpls_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_verdict       (rsp_verdict),
   .rsp_first_online  (rsp_first_online),
   .rsp_second_online (rsp_second_online),
   .rsp_link_online   (rsp_link_online),
   .rsp_last          (rsp_last)
);

[tb/sv/testbench.sv]
// Self-checking testbench of the two-peer link supervisor: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;

   localparam logic [2:0] CSR_UNMAPPED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = tpls_pkg::OP_FRAME;
   logic [7:0]  req_frame_type = 8'd0;
   logic [7:0]  req_frame_length = 8'd0;
   logic [7:0]  req_frame_role = 8'd0;
   logic [15:0] req_frame_sequence = 16'd0;
   logic [31:0] req_now_ms = 32'd0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_verdict;
   logic [7:0]  rsp_tx_type;
   logic [15:0] rsp_tx_sequence;
   logic [31:0] rsp_tx_time;
   logic        rsp_first_online;
   logic        rsp_second_online;
   logic        rsp_link_online;
   logic [7:0]  rsp_peer_role;
   logic [31:0] rsp_accepted_frames;
   logic [31:0] rsp_offline_events;
   logic        rsp_last;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [tpls_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [39:0] csr_wdata = 40'd0;

   // Travels with the request payload: a verdict typed into the directed table.
   logic        row_typed = 1'b0;
   logic [2:0]  row_verdict = tpls_pkg::VERDICT_ACCEPTED;

   two_peer_link_supervisor_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_frame_type      (req_frame_type),
      .req_frame_length    (req_frame_length),
      .req_frame_role      (req_frame_role),
      .req_frame_sequence  (req_frame_sequence),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_verdict         (rsp_verdict),
      .rsp_tx_type         (rsp_tx_type),
      .rsp_tx_sequence     (rsp_tx_sequence),
      .rsp_tx_time         (rsp_tx_time),
      .rsp_first_online    (rsp_first_online),
      .rsp_second_online   (rsp_second_online),
      .rsp_link_online     (rsp_link_online),
      .rsp_peer_role       (rsp_peer_role),
      .rsp_accepted_frames (rsp_accepted_frames),
      .rsp_offline_events  (rsp_offline_events),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Supervisor model: registers and link state.
   // ---------------------------------------------------------------
   logic [15:0] m_timeout, m_hello_ivl, m_heartbeat_ivl, m_status_ivl;
   logic [39:0] m_msg_codes;
   logic [23:0] m_role_codes;
   logic [7:0]  m_status_flags;
   logic        first_seen, second_seen, first_up, second_up, started_flag;
   logic [15:0] first_seq, second_seq, own_seq;
   logic [31:0] first_rx, second_rx, presence_time, status_time;
   logic [7:0]  peer_role_seen;
   logic [31:0] accepted_count, offline_count;

   tpls_pkg::rsp_out_type awaited_results[$];
   int          mismatch_count = 0;

   task automatic reset_model();
      m_timeout       = tpls_pkg::OFFLINE_TIMEOUT_RESET;
      m_hello_ivl     = tpls_pkg::HELLO_INTERVAL_RESET;
      m_heartbeat_ivl = tpls_pkg::HEARTBEAT_INTERVAL_RESET;
      m_status_ivl    = tpls_pkg::STATUS_INTERVAL_RESET;
      m_msg_codes     = 40'd0;
      m_role_codes    = 24'd0;
      m_status_flags  = 8'd0;
      first_seen = 1'b0; second_seen = 1'b0;
      first_up = 1'b0; second_up = 1'b0; started_flag = 1'b0;
      first_seq = 16'd0; second_seq = 16'd0; own_seq = 16'd0;
      first_rx = 32'd0; second_rx = 32'd0;
      presence_time = 32'd0; status_time = 32'd0;
      peer_role_seen = 8'd0;
      accepted_count = 32'd0; offline_count = 32'd0;
   endtask

   task automatic apply_register_write(input logic [2:0] index, input logic [39:0] data);
      case (index)
         tpls_pkg::CSR_OFFLINE_TIMEOUT:    m_timeout = data[15:0];
         tpls_pkg::CSR_HELLO_INTERVAL:     m_hello_ivl = data[15:0];
         tpls_pkg::CSR_HEARTBEAT_INTERVAL: m_heartbeat_ivl = data[15:0];
         tpls_pkg::CSR_STATUS_INTERVAL:    m_status_ivl = data[15:0];
         tpls_pkg::CSR_MESSAGE_CODES:      m_msg_codes = data;
         tpls_pkg::CSR_ROLE_CODES:         m_role_codes = data[23:0];
         tpls_pkg::CSR_STATUS_FLAGS:       m_status_flags = data[7:0];
         default: ;
      endcase
   endtask

   function automatic logic [7:0] msg_code(int i);
      return m_msg_codes[8*i +: 8];
   endfunction

   function automatic logic [7:0] role_code(int i);
      return m_role_codes[8*i +: 8];
   endfunction

   function automatic tpls_pkg::rsp_out_type status_result(logic [1:0] kind,
                                                           logic [2:0] verdict,
                                                           logic [7:0] ty, logic [15:0] seq,
                                                           logic [31:0] stamp);
      tpls_pkg::rsp_out_type r;
      r.result_kind     = kind;
      r.verdict         = verdict;
      r.tx_type         = ty;
      r.tx_sequence     = seq;
      r.tx_time         = stamp;
      r.first_online    = first_up;
      r.second_online   = second_up;
      r.link_online     = first_up && second_up;
      r.peer_role       = peer_role_seen;
      r.accepted_frames = accepted_count;
      r.offline_events  = offline_count;
      r.last            = 1'b0;
      return r;
   endfunction

   function automatic logic [2:0] frame_verdict(logic [7:0] ty, logic [7:0] len,
                                                logic [7:0] role, logic [15:0] seq,
                                                logic [31:0] now);
      logic        from_first;
      logic        seen;
      logic [15:0] prev, gap;
      if (ty == msg_code(0) || ty == msg_code(1)) return tpls_pkg::VERDICT_SHADOW;
      if (ty != msg_code(2) && ty != msg_code(3) && ty != msg_code(4))
         return tpls_pkg::VERDICT_UNSUPPORTED;
      if (len == 8'd0) return tpls_pkg::VERDICT_UNSUPPORTED;
      // The first peer wins when both roles share a code.
      if (role == role_code(0)) from_first = 1'b1;
      else if (role == role_code(1)) from_first = 1'b0;
      else return tpls_pkg::VERDICT_UNSUPPORTED;
      seen = from_first ? first_seen : second_seen;
      prev = from_first ? first_seq : second_seq;
      // A hello restarts the sequence; everything else must be newer by serial arithmetic.
      if (ty != msg_code(2) && seen) begin
         gap = seq - prev;
         if (gap == 16'd0) return tpls_pkg::VERDICT_DUPLICATE;
         if (gap[15]) return tpls_pkg::VERDICT_OUT_OF_ORDER;
      end
      if (from_first) begin
         first_seen = 1'b1; first_seq = seq; first_rx = now;
      end else begin
         second_seen = 1'b1; second_seq = seq; second_rx = now;
      end
      peer_role_seen = role;
      accepted_count++;
      return tpls_pkg::VERDICT_ACCEPTED;
   endfunction

   task automatic queue_request_results(input logic op, input logic [7:0] ty,
                                        input logic [7:0] len, input logic [7:0] role,
                                        input logic [15:0] seq, input logic [31:0] now,
                                        input logic typed, input logic [2:0] typed_verdict);
      tpls_pkg::rsp_out_type burst[3];
      int          n;
      logic        old1, old2;
      logic [2:0]  v;
      logic [15:0] period;
      logic [31:0] age;
      n = 0;
      if (op == tpls_pkg::OP_FRAME) begin
         v = frame_verdict(ty, len, role, seq, now);
         if (typed) v = typed_verdict;
         burst[0] = status_result(tpls_pkg::KIND_VERDICT, v, 8'd0, 16'd0, 32'd0);
         n = 1;
      end else begin
         old1 = first_up;
         old2 = second_up;
         age = now - first_rx;
         first_up = first_seen && (age < {16'd0, m_timeout});
         age = now - second_rx;
         second_up = second_seen && (age < {16'd0, m_timeout});
         if ((old1 && !first_up) || (old2 && !second_up)) offline_count++;
         burst[0] = status_result(tpls_pkg::KIND_TICK, tpls_pkg::VERDICT_ACCEPTED,
                                  8'd0, 16'd0, 32'd0);
         n = 1;
         period = first_up ? m_heartbeat_ivl : m_hello_ivl;
         if (!started_flag || (now - presence_time) >= {16'd0, period}) begin
            presence_time = now;
            burst[n] = status_result(tpls_pkg::KIND_TX, tpls_pkg::VERDICT_ACCEPTED,
                                     first_up ? msg_code(3) : msg_code(2), own_seq, now);
            n++;
            own_seq++;
         end
         if (!started_flag || (now - status_time) >= {16'd0, m_status_ivl}) begin
            status_time = now;
            burst[n] = status_result(tpls_pkg::KIND_TX, tpls_pkg::VERDICT_ACCEPTED,
                                     msg_code(4), own_seq, now);
            n++;
            own_seq++;
         end
         started_flag = 1'b1;
      end
      burst[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) awaited_results.push_back(burst[k]);
   endtask

   function automatic int field_diff(string name, logic [39:0] want, logic [39:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : scoreboard
      tpls_pkg::rsp_out_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result arrived with no request outstanding");
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               mismatch_count += field_diff("result_kind", 40'(want.result_kind),
                                            40'(rsp_result_kind));
               mismatch_count += field_diff("verdict", 40'(want.verdict), 40'(rsp_verdict));
               mismatch_count += field_diff("tx_type", 40'(want.tx_type), 40'(rsp_tx_type));
               mismatch_count += field_diff("tx_sequence", 40'(want.tx_sequence),
                                            40'(rsp_tx_sequence));
               mismatch_count += field_diff("tx_time", 40'(want.tx_time), 40'(rsp_tx_time));
               mismatch_count += field_diff("first_online", 40'(want.first_online),
                                            40'(rsp_first_online));
               mismatch_count += field_diff("second_online", 40'(want.second_online),
                                            40'(rsp_second_online));
               mismatch_count += field_diff("link_online", 40'(want.link_online),
                                            40'(rsp_link_online));
               mismatch_count += field_diff("peer_role", 40'(want.peer_role),
                                            40'(rsp_peer_role));
               mismatch_count += field_diff("accepted_frames", 40'(want.accepted_frames),
                                            40'(rsp_accepted_frames));
               mismatch_count += field_diff("offline_events", 40'(want.offline_events),
                                            40'(rsp_offline_events));
               mismatch_count += field_diff("last", 40'(want.last), 40'(rsp_last));
            end
         end
         if (req_valid && !req_stall)
            queue_request_results(req_operation, req_frame_type, req_frame_length,
                                  req_frame_role, req_frame_sequence, req_now_ms,
                                  row_typed, row_verdict);
         if (csr_valid && csr_ready) apply_register_write(csr_index, csr_wdata);
      end
   end

   // ---------------------------------------------------------------
   // Idle gaps: mostly short, a few long, with calm stretches of none.
   // ---------------------------------------------------------------
   function automatic int random_gap(inout int calm_left);
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   initial begin : stall_driver
      int n;
      int calm;
      calm = 0;
      @(posedge clock);
      forever begin
         n = random_gap(calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------
   // Request and register drivers.
   // ---------------------------------------------------------------
   int          req_calm = 0;
   logic [39:0] gen_codes = 40'd0;
   logic [23:0] gen_roles = 24'd0;
   logic [15:0] gen_seq [2] = '{16'd0, 16'd0};
   logic [31:0] sim_now = 32'd0;

   task automatic send_request(input logic op, input logic [7:0] ty, input logic [7:0] len,
                               input logic [7:0] role, input logic [15:0] seq,
                               input logic [31:0] now, input logic typed,
                               input logic [2:0] verdict);
      int n;
      n = random_gap(req_calm);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_frame_type     <= ty;
      req_frame_length   <= len;
      req_frame_role     <= role;
      req_frame_sequence <= seq;
      req_now_ms         <= now;
      row_typed          <= typed;
      row_verdict        <= verdict;
      do @(posedge clock); while (req_stall);
   endtask

   // Leaves csr_valid high so that writes can follow back to back.
   task automatic write_register(input logic [2:0] index, input logic [39:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [15:0] timeout, input logic [15:0] hello,
                            input logic [15:0] heartbeat, input logic [15:0] status,
                            input logic [39:0] codes, input logic [23:0] roles,
                            input logic [7:0] flags);
      write_register(tpls_pkg::CSR_OFFLINE_TIMEOUT, {24'd0, timeout});
      write_register(tpls_pkg::CSR_HELLO_INTERVAL, {24'd0, hello});
      write_register(tpls_pkg::CSR_HEARTBEAT_INTERVAL, {24'd0, heartbeat});
      write_register(tpls_pkg::CSR_STATUS_INTERVAL, {24'd0, status});
      write_register(tpls_pkg::CSR_MESSAGE_CODES, codes);
      write_register(tpls_pkg::CSR_ROLE_CODES, {16'd0, roles});
      write_register(tpls_pkg::CSR_STATUS_FLAGS, {32'd0, flags});
      // The unmapped index must leave every register alone.
      write_register(CSR_UNMAPPED, 40'({$urandom, $urandom}));
      csr_valid <= 1'b0;
      @(posedge clock);
      gen_codes = codes;
      gen_roles = roles;
   endtask

   task automatic wait_until_quiet();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_request();
      logic        op;
      logic [7:0]  ty, len, role;
      logic [15:0] seq, delta;
      int          pick, peer;
      pick = $urandom_range(0, 99);
      if (pick < 80) sim_now += $urandom_range(0, 300);
      else if (pick < 95) sim_now += $urandom_range(300, 5000);
      else sim_now += $urandom;
      op   = tpls_pkg::OP_FRAME;
      ty   = 8'($urandom);
      len  = 8'($urandom);
      role = 8'($urandom);
      seq  = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         op = tpls_pkg::OP_TICK;
      end else if (pick < 80) begin
         // Well-formed frame from a known peer, sequence mostly close to the last one sent.
         peer = $urandom_range(0, 1);
         ty   = gen_codes[8*$urandom_range(2, 4) +: 8];
         role = gen_roles[8*peer +: 8];
         len  = 8'($urandom_range(1, 255));
         pick = $urandom_range(0, 99);
         if (pick < 40) delta = 16'd1;
         else if (pick < 60) delta = 16'($urandom_range(2, 100));
         else if (pick < 70) delta = 16'd0;
         else if (pick < 85) delta = 16'd0 - 16'($urandom_range(1, 100));
         else if (pick < 90) delta = 16'h8000;
         else delta = 16'($urandom);
         seq = gen_seq[peer] + delta;
         if (delta != 16'd0 && !delta[15]) gen_seq[peer] = seq;
      end else begin
         case ($urandom_range(0, 3))
            0: ty = gen_codes[8*$urandom_range(0, 1) +: 8];
            1: begin
               ty  = gen_codes[23:16];
               len = 8'd0;
            end
            2: ty = gen_codes[31:24];
            default: ;
         endcase
      end
      send_request(op, ty, len, role, seq, sim_now, 1'b0, tpls_pkg::VERDICT_ACCEPTED);
   endtask

   // ---------------------------------------------------------------
   // Directed table. Column one selects the register setting in force.
   // ---------------------------------------------------------------
   typedef struct {
      int          cfg_set;
      logic        op;
      logic [7:0]  ftype;
      logic [7:0]  flen;
      logic [7:0]  frole;
      logic [15:0] fseq;
      logic [31:0] now;
      bit          typed;
      logic [2:0]  verdict;
   } stim_row_type;

   stim_row_type directed_rows [24] = '{
      // Reset values: every type code is zero.
      '{0, tpls_pkg::OP_FRAME, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000,
        1'b1, tpls_pkg::VERDICT_SHADOW},
      '{0, tpls_pkg::OP_FRAME, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
        1'b1, tpls_pkg::VERDICT_UNSUPPORTED},
      '{0, tpls_pkg::OP_TICK,  8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      // Distinct codes, default intervals.
      '{1, tpls_pkg::OP_FRAME, 8'h10, 8'h04, 8'h01, 16'h0001, 32'd1,
        1'b1, tpls_pkg::VERDICT_SHADOW},
      '{1, tpls_pkg::OP_FRAME, 8'h11, 8'h04, 8'h01, 16'h0001, 32'd2,
        1'b1, tpls_pkg::VERDICT_SHADOW},
      '{1, tpls_pkg::OP_FRAME, 8'h00, 8'h04, 8'h01, 16'h0001, 32'd3,
        1'b1, tpls_pkg::VERDICT_UNSUPPORTED},
      '{1, tpls_pkg::OP_FRAME, 8'h20, 8'h00, 8'h01, 16'h0001, 32'd4,
        1'b1, tpls_pkg::VERDICT_UNSUPPORTED},
      '{1, tpls_pkg::OP_FRAME, 8'h20, 8'h01, 8'h07, 16'h0001, 32'd5,
        1'b1, tpls_pkg::VERDICT_UNSUPPORTED},
      '{1, tpls_pkg::OP_FRAME, 8'h21, 8'h08, 8'h01, 16'hFFFF, 32'd10,
        1'b1, tpls_pkg::VERDICT_ACCEPTED},
      '{1, tpls_pkg::OP_FRAME, 8'h21, 8'h08, 8'h01, 16'hFFFF, 32'd20,
        1'b1, tpls_pkg::VERDICT_DUPLICATE},
      '{1, tpls_pkg::OP_FRAME, 8'h21, 8'h08, 8'h01, 16'h7FFF, 32'd30,
        1'b1, tpls_pkg::VERDICT_OUT_OF_ORDER},
      '{1, tpls_pkg::OP_FRAME, 8'h21, 8'h08, 8'h01, 16'h0000, 32'd40,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{1, tpls_pkg::OP_FRAME, 8'h22, 8'hFF, 8'h02, 16'h1234, 32'd50,
        1'b1, tpls_pkg::VERDICT_ACCEPTED},
      '{1, tpls_pkg::OP_FRAME, 8'h22, 8'hFF, 8'h02, 16'h1233, 32'd55,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{1, tpls_pkg::OP_FRAME, 8'h20, 8'h01, 8'h01, 16'h0000, 32'd60,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{1, tpls_pkg::OP_TICK,  8'h00, 8'h00, 8'h00, 16'h0000, 32'd100,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{1, tpls_pkg::OP_TICK,  8'h00, 8'h00, 8'h00, 16'h0000, 32'd1100,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{1, tpls_pkg::OP_TICK,  8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      // Colliding codes, zero timeout and zero intervals.
      '{2, tpls_pkg::OP_FRAME, 8'h40, 8'h01, 8'h09, 16'h0005, 32'h10,
        1'b1, tpls_pkg::VERDICT_SHADOW},
      '{2, tpls_pkg::OP_FRAME, 8'h42, 8'h01, 8'h09, 16'h0005, 32'h11,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{2, tpls_pkg::OP_FRAME, 8'h42, 8'h01, 8'h09, 16'h0005, 32'h12,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{2, tpls_pkg::OP_TICK,  8'h00, 8'h00, 8'h00, 16'h0000, 32'h20,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{2, tpls_pkg::OP_TICK,  8'h00, 8'h00, 8'h00, 16'h0000, 32'h20,
        1'b0, tpls_pkg::VERDICT_ACCEPTED},
      '{2, tpls_pkg::OP_FRAME, 8'h43, 8'h01, 8'h09, 16'h0006, 32'h21,
        1'b1, tpls_pkg::VERDICT_UNSUPPORTED}
   };

   initial begin : stimulus
      int          cfg_now;
      logic [15:0] t_out, t_hello, t_beat, t_stat;
      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      cfg_now = 0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg_set != cfg_now) begin
            cfg_now = directed_rows[i].cfg_set;
            wait_until_quiet();
            if (cfg_now == 1)
               configure(16'd1000, 16'd1000, 16'd250, 16'd500,
                         40'h22_21_20_11_10, 24'h03_02_01, 8'hA5);
            else
               configure(16'd0, 16'd0, 16'd0, 16'd0,
                         40'h40_42_42_41_40, 24'h09_09_09, 8'h5A);
         end
         send_request(directed_rows[i].op, directed_rows[i].ftype, directed_rows[i].flen,
                      directed_rows[i].frole, directed_rows[i].fseq, directed_rows[i].now,
                      directed_rows[i].typed, directed_rows[i].verdict);
      end

      for (int phase = 0; phase < 5; phase++) begin
         wait_until_quiet();
         if (phase == 0) begin
            t_out = 16'd1; t_hello = 16'd1; t_beat = 16'd1; t_stat = 16'd1;
         end else if (phase == 1) begin
            t_out = 16'hFFFF; t_hello = 16'hFFFF; t_beat = 16'hFFFF; t_stat = 16'hFFFF;
         end else begin
            t_out   = 16'($urandom_range(20, 3000));
            t_hello = 16'($urandom_range(1, 1500));
            t_beat  = 16'($urandom_range(1, 1500));
            t_stat  = 16'($urandom_range(1, 1500));
         end
         configure(t_out, t_hello, t_beat, t_stat, 40'({$urandom, $urandom}),
                   24'($urandom), 8'($urandom));
         // One phase starts just short of the time wrap.
         sim_now = (phase == 2) ? 32'hFFFF_F000 : 32'($urandom);
         repeat (29) send_random_request();
      end

      wait_until_quiet();
      repeat (10) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d expected results never arrived", awaited_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
